// ===== src/ulcs_pkg.sv =====
// ----------------------------------------------------------------------------
// ulcs_pkg
// Shared types and codes for the unconstrained LP column solver.
// ----------------------------------------------------------------------------
package ulcs_pkg;

  typedef enum logic [1:0] {
    CFG_DUAL_TOLERANCE   = 2'd0,
    CFG_PRIMAL_TOLERANCE = 2'd1,
    CFG_MAXIMIZE         = 2'd2,
    CFG_OBJECTIVE_OFFSET = 2'd3
  } cfg_index_t;

  typedef enum logic [1:0] {
    COL_AT_LOWER = 2'd0,
    COL_AT_UPPER = 2'd1,
    COL_FREE     = 2'd2
  } col_status_t;

  typedef enum logic [1:0] {
    MODEL_OPTIMAL    = 2'd0,
    MODEL_INFEASIBLE = 2'd1,
    MODEL_UNBOUNDED  = 2'd2
  } solve_status_t;

  localparam logic [31:0] Q16_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] Q16_MIN = 32'h8000_0000;

  typedef struct packed {
    logic [31:0] cost;
    logic [31:0] lower_bound;
    logic [31:0] upper_bound;
    logic        lower_minus_inf;
    logic        lower_plus_inf;
    logic        upper_plus_inf;
    logic        upper_minus_inf;
    logic        first_column;
    logic        last_column;
  } col_word_t;

  typedef struct packed {
    logic [31:0] value;
    col_status_t status;
    logic [31:0] pinf;
    logic        pinf_inf;
    logic        primal_bad;
    logic [31:0] dinf;
    logic        dual_bad;
  } col_eval_t;

endpackage

// ===== src/unconstrained_lp_column_solver_unit.sv =====
// ----------------------------------------------------------------------------
// unconstrained_lp_column_solver_unit
// Solves a row-free linear program one column word at a time.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one column word: cost, bounds,
//   infinity flags, first_column and last_column. Output channel
//   (out_valid / out_stall) returns one result word per column: value, status,
//   the column cost as dual, and the running objective and infeasibility statistics.
//   Configuration registers are written through cfg_write / cfg_index /
//   cfg_data while the block is idle; first_column loads the objective offset
//   and clears the statistics.
//   An accepted word passes the input and evaluation registers before out_valid rises.
//   Throughput: one column per cycle while out_stall is low; the running sums close a
//   loop through the 64-bit saturating adder and the statistics registers.
//   Reset clears all valid flags, statistics and the objective and sets both
//   tolerances to one LSB, sense to minimize and the offset to zero.
//   While out_stall holds a result, the pipeline keeps filling until every
//   stage is full; then in_stall rises. No word is dropped or repeated.
// ----------------------------------------------------------------------------
module unconstrained_lp_column_solver_unit #(
  parameter int COUNTER_BITS = 20
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_write,
  input  logic [1:0]              cfg_index,
  input  logic [63:0]             cfg_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [31:0]             cost,
  input  logic [31:0]             lower_bound,
  input  logic [31:0]             upper_bound,
  input  logic                    lower_minus_inf,
  input  logic                    lower_plus_inf,
  input  logic                    upper_plus_inf,
  input  logic                    upper_minus_inf,
  input  logic                    first_column,
  input  logic                    last_column,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [31:0]             column_value,
  output logic [1:0]              column_status,
  output logic [31:0]             column_dual,
  output logic [63:0]             objective,
  output logic [COUNTER_BITS-1:0] primal_infeasible_count,
  output logic [COUNTER_BITS-1:0] dual_infeasible_count,
  output logic [30:0]             primal_infeas_peak,
  output logic [30:0]             dual_infeas_peak,
  output logic [39:0]             sum_primal_infeasibility,
  output logic [39:0]             sum_dual_infeasibility,
  output logic [1:0]              solve_status,
  output logic                    last
);
  import ulcs_pkg::*;

  logic [30:0] dual_tolerance, primal_tolerance;
  logic        maximize;
  logic [63:0] objective_offset;

  logic        s1_valid, s2_valid;
  logic        accept, s2_load, s3_load;
  col_word_t   s1_word;
  col_eval_t   eval;
  col_eval_t   s2_eval;
  logic [63:0] s2_product;
  logic [31:0] s2_cost;
  logic        s2_first, s2_last;

  logic [63:0]             obj_base;
  logic [64:0]             obj_sum;
  logic [63:0]             objective_next;
  logic [COUNTER_BITS-1:0] pcount_base, dcount_base, pcount_next, dcount_next;
  logic [30:0]             pmax_base, dmax_base, p_clip, d_clip;
  logic [39:0]             psum_base, dsum_base;
  logic [40:0]             psum_w, dsum_w;
  solve_status_t           solve_status_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      dual_tolerance   <= 31'd1;
      primal_tolerance <= 31'd1;
      maximize         <= 1'b0;
      objective_offset <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_DUAL_TOLERANCE:   dual_tolerance   <= cfg_data[30:0];
        CFG_PRIMAL_TOLERANCE: primal_tolerance <= cfg_data[30:0];
        CFG_MAXIMIZE:         maximize         <= cfg_data[0];
        CFG_OBJECTIVE_OFFSET: objective_offset <= cfg_data;
        default: ;
      endcase
    end
  end

  assign s3_load  = s2_valid && (!out_valid || !out_stall);
  assign s2_load  = s1_valid && (!s2_valid || s3_load);
  assign in_stall = s1_valid && !s2_load;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s2_load) begin
        s1_valid <= 1'b0;
      end
      if (s2_load) begin
        s2_valid <= 1'b1;
      end else if (s3_load) begin
        s2_valid <= 1'b0;
      end
      if (s3_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_word <= '{cost: cost, lower_bound: lower_bound, upper_bound: upper_bound,
                   lower_minus_inf: lower_minus_inf, lower_plus_inf: lower_plus_inf,
                   upper_plus_inf: upper_plus_inf, upper_minus_inf: upper_minus_inf,
                   first_column: first_column, last_column: last_column};
    end
  end

  ulcs_column_eval u_eval (
    .col              (s1_word),
    .dual_tolerance   (dual_tolerance),
    .primal_tolerance (primal_tolerance),
    .maximize         (maximize),
    .eval             (eval)
  );

  always_ff @(posedge clk) begin
    if (s2_load) begin
      s2_eval    <= eval;
      s2_product <= $signed(eval.value) * $signed(s1_word.cost);
      s2_cost    <= s1_word.cost;
      s2_first   <= s1_word.first_column;
      s2_last    <= s1_word.last_column;
    end
  end

  always_comb begin
    obj_base    = s2_first ? objective_offset : objective;
    pcount_base = s2_first ? '0 : primal_infeasible_count;
    dcount_base = s2_first ? '0 : dual_infeasible_count;
    pmax_base   = s2_first ? '0 : primal_infeas_peak;
    dmax_base   = s2_first ? '0 : dual_infeas_peak;
    psum_base   = s2_first ? '0 : sum_primal_infeasibility;
    dsum_base   = s2_first ? '0 : sum_dual_infeasibility;

    obj_sum = {obj_base[63], obj_base} + {s2_product[63], s2_product};
    if (obj_sum[64] != obj_sum[63]) begin
      objective_next = obj_sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      objective_next = obj_sum[63:0];
    end

    pcount_next = pcount_base;
    if (s2_eval.primal_bad && (pcount_base != '1)) begin
      pcount_next = pcount_base + 1'b1;
    end
    dcount_next = dcount_base;
    if (s2_eval.dual_bad && (dcount_base != '1)) begin
      dcount_next = dcount_base + 1'b1;
    end

    p_clip = (s2_eval.pinf_inf || s2_eval.pinf[31]) ? Q16_MAX[30:0] : s2_eval.pinf[30:0];
    d_clip = s2_eval.dinf[31] ? Q16_MAX[30:0] : s2_eval.dinf[30:0];

    psum_w = {1'b0, psum_base} + {9'd0, s2_eval.pinf};
    dsum_w = {1'b0, dsum_base} + {9'd0, s2_eval.dinf};

    solve_status_next = MODEL_OPTIMAL;
    if (s2_last) begin
      if (pcount_next != '0) begin
        solve_status_next = MODEL_INFEASIBLE;
      end else if (dcount_next != '0) begin
        solve_status_next = MODEL_UNBOUNDED;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      objective                <= '0;
      primal_infeasible_count  <= '0;
      dual_infeasible_count    <= '0;
      primal_infeas_peak       <= '0;
      dual_infeas_peak         <= '0;
      sum_primal_infeasibility <= '0;
      sum_dual_infeasibility   <= '0;
    end else if (s3_load) begin
      objective                <= objective_next;
      primal_infeasible_count  <= pcount_next;
      dual_infeasible_count    <= dcount_next;
      primal_infeas_peak       <= (p_clip > pmax_base) ? p_clip : pmax_base;
      dual_infeas_peak         <= (d_clip > dmax_base) ? d_clip : dmax_base;
      sum_primal_infeasibility <= (s2_eval.pinf_inf || psum_w[40]) ? '1 : psum_w[39:0];
      sum_dual_infeasibility   <= dsum_w[40] ? '1 : dsum_w[39:0];
    end
  end

  always_ff @(posedge clk) begin
    if (s3_load) begin
      column_value  <= s2_eval.value;
      column_status <= s2_eval.status;
      column_dual   <= s2_cost;
      solve_status  <= solve_status_next;
      last          <= s2_last;
    end
  end

`ifndef ASSERT_OFF
  a_stall_needs_word: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> !in_stall)
    else $error("input stalled with empty input register");

  a_stats_hold: assert property (@(posedge clk) disable iff (rst)
    !s3_load |=> $stable(objective) && $stable(primal_infeasible_count) &&
                 $stable(sum_dual_infeasibility))
    else $error("statistics changed without a new word");

  a_status_on_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (solve_status != MODEL_OPTIMAL) |-> last)
    else $error("solve status on a word that is not last");

  a_max_sum_agree: assert property (@(posedge clk) disable iff (rst)
    (primal_infeas_peak != '0) |-> (sum_primal_infeasibility != '0))
    else $error("primal peak and sum disagree");
`endif

endmodule

// ===== src/ulcs_column_eval.sv =====
// ----------------------------------------------------------------------------
// ulcs_column_eval
// Picks value and status of one column and its primal and dual infeasibility.
// ----------------------------------------------------------------------------
module ulcs_column_eval (
  input  ulcs_pkg::col_word_t col,
  input  logic [30:0]         dual_tolerance,
  input  logic [30:0]         primal_tolerance,
  input  logic                maximize,
  output ulcs_pkg::col_eval_t eval
);
  import ulcs_pkg::*;

  logic               l_neg, l_pos, l_fin, u_neg, u_pos, u_fin;
  logic               crossed;
  logic [31:0]        lower_val, upper_val;
  logic signed [32:0] cost_x, dual, neg_dual, adual, dtol, pdiff;
  logic               ge_tol, le_ntol;
  logic signed [32:0] dinf_w;

  assign l_neg = col.lower_minus_inf;
  assign l_pos = !col.lower_minus_inf && col.lower_plus_inf;
  assign l_fin = !l_neg && !l_pos;
  assign u_pos = col.upper_plus_inf;
  assign u_neg = !col.upper_plus_inf && col.upper_minus_inf;
  assign u_fin = !u_neg && !u_pos;

  assign crossed = (l_pos && !u_pos) || (l_fin && u_neg) ||
                   (l_fin && u_fin &&
                    ($signed(col.lower_bound) > $signed(col.upper_bound)));

  assign lower_val = l_neg ? Q16_MIN : (l_pos ? Q16_MAX : col.lower_bound);
  assign upper_val = u_neg ? Q16_MIN : (u_pos ? Q16_MAX : col.upper_bound);

  assign cost_x   = {col.cost[31], col.cost};
  assign dual     = maximize ? -cost_x : cost_x;
  assign neg_dual = -dual;
  assign adual    = dual[32] ? neg_dual : dual;
  assign dtol     = {2'b00, dual_tolerance};
  assign ge_tol   = dual >= dtol;
  assign le_ntol  = dual <= -dtol;
  assign pdiff    = {col.lower_bound[31], col.lower_bound} -
                    {col.upper_bound[31], col.upper_bound};

  always_comb begin
    eval.value    = lower_val;
    eval.status   = COL_AT_LOWER;
    eval.pinf     = '0;
    eval.pinf_inf = 1'b0;
    dinf_w        = '0;
    if (crossed) begin
      if (l_pos) begin
        eval.pinf_inf = 1'b1;
        if (u_neg) begin
          eval.value  = '0;
          eval.status = COL_FREE;
          dinf_w      = adual;
        end else begin
          eval.value  = upper_val;
          eval.status = COL_AT_UPPER;
          dinf_w      = (dual > 0) ? dual : '0;
        end
      end else begin
        eval.value  = lower_val;
        eval.status = COL_AT_LOWER;
        if (u_neg) begin
          eval.pinf_inf = 1'b1;
        end else begin
          eval.pinf = pdiff[31:0];
        end
        dinf_w = dual[32] ? neg_dual : '0;
      end
    end else if (l_neg && u_pos) begin
      eval.value  = '0;
      eval.status = COL_FREE;
      dinf_w      = adual;
    end else if (ge_tol) begin
      if (!l_neg) begin
        eval.value  = lower_val;
        eval.status = COL_AT_LOWER;
      end else begin
        eval.value  = upper_val;
        eval.status = COL_AT_UPPER;
        dinf_w      = dual;
      end
    end else if (le_ntol) begin
      if (!u_pos) begin
        eval.value  = upper_val;
        eval.status = COL_AT_UPPER;
      end else begin
        eval.value  = lower_val;
        eval.status = COL_AT_LOWER;
        dinf_w      = neg_dual;
      end
    end else begin
      if (l_neg) begin
        eval.value  = upper_val;
        eval.status = COL_AT_UPPER;
      end else begin
        eval.value  = lower_val;
        eval.status = COL_AT_LOWER;
      end
      dinf_w = adual;
    end
    eval.dinf       = dinf_w[31:0];
    eval.primal_bad = eval.pinf_inf || (eval.pinf > {1'b0, primal_tolerance});
    eval.dual_bad   = eval.dinf > {1'b0, dual_tolerance};
  end

endmodule
